// ----- src/float_to_pcm_sample_packer_top_defines.svh -----
// assertion macros for the float to pcm sample packer
// expects signals named clock and reset in the module that uses them
`ifndef FLOAT_TO_PCM_SAMPLE_PACKER_TOP_DEFINES_SVH
`define FLOAT_TO_PCM_SAMPLE_PACKER_TOP_DEFINES_SVH

// same-cycle implication
`define FPSP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fpsp assertion failed");

// next-cycle implication
`define FPSP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fpsp assertion failed");

`endif

// ----- src/fpsp_pkg.sv -----
// shared types and constants for the float to pcm sample packer
// no dependencies
package fpsp_pkg;

   localparam logic [31:0] REG_CONTAINER_BYTES = 32'd0;
   localparam logic [31:0] REG_VALID_BITS      = 32'd1;
   localparam logic [31:0] REG_UNSIGNED_MODE   = 32'd2;

   localparam logic [2:0] CONTAINER_BYTES_RESET = 3'd4;
   localparam logic [5:0] VALID_BITS_RESET      = 6'd32;
   localparam logic [2:0] MAX_BYTES             = 3'd4;
   localparam logic [5:0] UNSIGNED_BITS         = 6'd8;

   typedef struct packed {
      logic [2:0] container_bytes;
      logic [5:0] valid_bits;
      logic       unsigned_mode;
   } cfg_type;

endpackage

// ----- src/fpsp_csr.sv -----
// configuration registers of the float to pcm sample packer
// depends on fpsp_pkg
module fpsp_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [31:0]          csr_index,
   input  logic [31:0]          csr_wdata,
   output fpsp_pkg::cfg_type    cfg
);
   fpsp_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            fpsp_pkg::REG_CONTAINER_BYTES: cfg_in.container_bytes = csr_wdata[2:0];
            fpsp_pkg::REG_VALID_BITS:      cfg_in.valid_bits      = csr_wdata[5:0];
            fpsp_pkg::REG_UNSIGNED_MODE:   cfg_in.unsigned_mode   = csr_wdata[0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.container_bytes <= fpsp_pkg::CONTAINER_BYTES_RESET;
         cfg_ff.valid_bits      <= fpsp_pkg::VALID_BITS_RESET;
         cfg_ff.unsigned_mode   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

// ----- src/fpsp_quant.sv -----
// clamp, scale and round one float sample to a signed n-bit value
// depends on fpsp_pkg
module fpsp_quant (
   input  logic [31:0]       sample,
   input  fpsp_pkg::cfg_type cfg,
   output logic [31:0]       q
);
   logic [5:0]  n;
   logic [4:0]  k;
   logic        neg, is_nan, big, no_bits;
   logic [7:0]  expo, e_eff, p;
   logic [23:0] mant;
   logic [54:0] shifted_m, prod;
   logic [55:0] prod_rnd, whole_w, half_w;
   logic [52:0] keep;
   logic        rnd_up;
   logic [31:0] mag;

   always_comb begin
      n         = cfg.unsigned_mode ? fpsp_pkg::UNSIGNED_BITS : cfg.valid_bits;
      k         = 5'(n - 6'd1);
      no_bits   = (n <= 6'd1) || (n > 6'd32);
      neg       = sample[31];
      expo      = sample[30:23];
      is_nan    = (expo == 8'hFF) && (sample[22:0] != 23'd0);
      big       = (expo >= 8'd127);
      mant      = {expo != 8'd0, sample[22:0]};
      e_eff     = (expo == 8'd0) ? 8'd1 : expo;
      p         = 8'd150 - e_eff;
      shifted_m = {31'd0, mant} << k;
      prod      = neg ? shifted_m : shifted_m - {31'd0, mant};
      // double precision keeps 53 significant bits, round to nearest even
      keep      = 53'd0;
      rnd_up    = 1'b0;
      if (prod[54]) begin
         keep     = prod[54:2];
         rnd_up   = prod[1] && (prod[0] || keep[0]);
         prod_rnd = {1'b0, 53'(keep + {52'd0, rnd_up}), 2'b00} +
                    {rnd_up && (keep == {53{1'b1}}), 55'd0};
      end else if (prod[53]) begin
         keep     = prod[53:1];
         rnd_up   = prod[0] && keep[0];
         prod_rnd = {2'b00, keep, 1'b0} + {1'b0, 53'd0, rnd_up, 1'b0};
      end else begin
         prod_rnd = {1'b0, prod};
      end
      whole_w = prod_rnd >> p;
      half_w  = prod_rnd >> (p - 8'd1);
      if (big) begin
         mag = neg ? (32'd1 << k) : ((32'd1 << k) - 32'd1);
      end else begin
         mag = whole_w[31:0] + {31'd0, half_w[0]};
      end
      if (no_bits || is_nan) begin
         q = 32'd0;
      end else begin
         q = neg ? (32'd0 - mag) : mag;
      end
   end
endmodule

// ----- src/fpsp_pack.sv -----
// place the quantized value into the pcm container word
// depends on fpsp_pkg
module fpsp_pack (
   input  logic [31:0]       q,
   input  fpsp_pkg::cfg_type cfg,
   output logic [31:0]       word
);
   logic [2:0]  bytes;
   logic [5:0]  cbits, shift;
   logic [31:0] shifted, mask;

   always_comb begin
      bytes   = (cfg.container_bytes > fpsp_pkg::MAX_BYTES) ? fpsp_pkg::MAX_BYTES
                                                            : cfg.container_bytes;
      cbits   = {bytes, 3'b000};
      shift   = (cbits > cfg.valid_bits) ? (cbits - cfg.valid_bits) : 6'd0;
      shifted = shift[5] ? 32'd0 : (q << shift[4:0]);
      mask    = 32'hFFFF_FFFF >> (6'd32 - cbits);
      if (bytes == 3'd0) begin
         word = 32'd0;
      end else if (cfg.unsigned_mode) begin
         word = {24'd0, ~q[7], q[6:0]};
      end else begin
         word = shifted & mask;
      end
   end
endmodule

// ----- src/float_to_pcm_sample_packer_top.sv -----
// top level of the float to pcm sample packer: input register, conversion, result register
// depends on fpsp_pkg, fpsp_csr, fpsp_quant, fpsp_pack and the defines header
//
//   channel   direction  handshake          payload
//   req       in         req_valid/stall    req_sample_float[31:0]
//   rsp       out        rsp_valid/stall    rsp_pcm_word[31:0]
//   csr       in         csr_valid/ready    csr_index[31:0], csr_wdata[31:0]
//
// one transaction per cycle sustained while rsp_stall is low; each passes the input register, then the result register
// conversion is a single combinational pass between the input and result registers
// reset is synchronous: both stages empty, registers back to 32-bit signed, 4 bytes
// rsp_stall holds the result register; the input register still fills behind it
// csr writes are taken every cycle
`include "float_to_pcm_sample_packer_top_defines.svh"
module float_to_pcm_sample_packer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_sample_float,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pcm_word,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_index,
   input  logic [31:0] csr_wdata
);
   fpsp_pkg::cfg_type cfg;

   logic        s1_valid_ff, s1_valid_in;
   logic [31:0] s1_sample_ff;
   logic        s2_valid_ff, s2_valid_in;
   logic [31:0] s2_word_ff;
   logic        s1_load, s2_load;
   logic [31:0] q, word;

   fpsp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // clamp, scale, round
   fpsp_quant u_quant (
      .sample (s1_sample_ff),
      .cfg    (cfg),
      .q      (q)
   );

   // shift into container, offset for unsigned mode
   fpsp_pack u_pack (
      .q    (q),
      .cfg  (cfg),
      .word (word)
   );

   // result register takes a new value when empty or drained this cycle
   assign s2_load   = !s2_valid_ff || !rsp_stall;
   assign s1_load   = !s1_valid_ff || s2_load;
   assign req_stall = !s1_load;

   always_comb begin
      s1_valid_in = s1_load ? req_valid : s1_valid_ff;
      s2_valid_in = s2_load ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_sample_ff <= req_sample_float;
      end
      if (s2_load) begin
         s2_word_ff <= word;
      end
   end

   assign rsp_valid    = s2_valid_ff;
   assign rsp_pcm_word = s2_word_ff;

   // stall only when both stages hold a transaction
   `FPSP_ASSERT_NOW(a_stall_full, req_stall, s1_valid_ff && s2_valid_ff && rsp_stall)
   // an accepted transaction lands in the input register
   `FPSP_ASSERT_NEXT(a_accept_lands, req_valid && !req_stall, s1_valid_ff)
   // a staged transaction moves on when the result register frees up
   `FPSP_ASSERT_NEXT(a_advance, s1_valid_ff && s2_load, s2_valid_ff)
endmodule

// ----- tb/float_to_pcm_sample_packer_top_test.sv -----
// self-checking testbench for the float to pcm sample packer top level
// depends on fpsp_pkg and float_to_pcm_sample_packer_top
module float_to_pcm_sample_packer_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 4;     // two-stage pipe plus margin
   localparam int RANDOM_ITEMS = 1200;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_sample_float;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_pcm_word;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_index;
   logic [31:0] csr_wdata;

   float_to_pcm_sample_packer_top dut (.*);

   // local copy of the configuration registers
   logic [2:0] cfg_bytes;
   logic [5:0] cfg_vbits;
   logic       cfg_unsigned;

   logic [31:0] pcm_expected[$];
   int          mismatch_count;
   int          checked_count;
   int          sample_count;
   int          cycle_count;
   bit          quiet;          // no idling on either side while set

   typedef struct {
      logic [31:0] sample;
      bit          typed;       // expected value given in the row
      logic [31:0] pcm;
   } sample_row_type;

   // rows run under the reset setting: 4-byte container, 32 valid bits, signed
   sample_row_type sample_table[] = '{
      '{32'h0000_0000, 1, 32'h0000_0000},   // plus zero
      '{32'h8000_0000, 1, 32'h0000_0000},   // minus zero
      '{32'h3F80_0000, 1, 32'h7FFF_FFFF},   // full scale positive
      '{32'hBF80_0000, 1, 32'h8000_0000},   // full scale negative
      '{32'h7F80_0000, 1, 32'h7FFF_FFFF},   // plus infinity clamps
      '{32'hFF80_0000, 1, 32'h8000_0000},   // minus infinity clamps
      '{32'h7FC0_0000, 1, 32'h0000_0000},   // quiet nan
      '{32'hFF80_0001, 1, 32'h0000_0000},   // signaling nan, sign set
      '{32'h7FFF_FFFF, 1, 32'h0000_0000},   // nan, all mantissa bits
      '{32'h4000_0000, 1, 32'h7FFF_FFFF},   // out of range high
      '{32'hC000_0000, 1, 32'h8000_0000},   // out of range low
      '{32'h7F7F_FFFF, 1, 32'h7FFF_FFFF},   // largest finite
      '{32'h0000_0001, 1, 32'h0000_0000},   // smallest denormal
      '{32'h807F_FFFF, 1, 32'h0000_0000},   // largest negative denormal
      '{32'hAF80_0000, 1, 32'hFFFF_FFFF},   // -2^-32: exact half rounds away
      '{32'hAF00_0000, 1, 32'h0000_0000},   // -2^-33: quarter rounds to zero
      '{32'h3F00_0000, 0, 32'h0},
      '{32'hBF00_0000, 0, 32'h0},
      '{32'h3F7F_FFFF, 0, 32'h0},
      '{32'hBF7F_FFFF, 0, 32'h0},
      '{32'h3E80_0001, 0, 32'h0},
      '{32'h2F80_0000, 0, 32'h0}
   };

   // setting list: bytes, valid bits, unsigned mode
   typedef struct {
      logic [31:0] bytes;
      logic [31:0] vbits;
      logic [31:0] unsg;
   } setting_type;

   setting_type setting_list[] = '{
      '{32'd4, 32'd32, 32'd0},
      '{32'd1, 32'd8,  32'd0},
      '{32'd2, 32'd16, 32'd0},
      '{32'd3, 32'd24, 32'd0},
      '{32'd4, 32'd24, 32'd0},   // left-justified 24 in 32
      '{32'd4, 32'd20, 32'd0},
      '{32'd1, 32'd16, 32'd0},   // wider than container, truncated
      '{32'd2, 32'd2,  32'd0},
      '{32'd4, 32'd1,  32'd0},   // one valid bit gives zero
      '{32'd3, 32'd0,  32'd0},
      '{32'd2, 32'd33, 32'd0},   // above 32 gives zero
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0},  // 7 bytes, 63 bits after masking
      '{32'd5, 32'd12, 32'd0},   // oversized container saturates
      '{32'd0, 32'd16, 32'd0},   // empty container
      '{32'd1, 32'd8,  32'd1},
      '{32'd4, 32'd32, 32'hFFFF_FFFF},
      '{32'd0, 32'd8,  32'd1},   // empty container wins over unsigned mode
      '{32'd6, 32'd3,  32'd1}
   };

   // round-half-away quantizer of a float bit pattern to n signed bits
   function automatic longint quantize_sample(logic [31:0] bits, int n);
      real         x, scaled, mag, fl;
      longint      neg_s, pos_s, whole, q;
      logic [63:0] dbits;
      if (n <= 1 || n > 32) return 0;
      if (bits[30:23] == 8'hFF && bits[22:0] != 0) return 0;
      if (bits[30:23] == 8'hFF) begin
         x = bits[31] ? -1.0 : 1.0;
      end else if (bits[30:23] == 8'h00) begin
         x = 0.0;   // denormals scale to well under one half
      end else begin
         dbits = {bits[31], 11'(bits[30:23]) + 11'd896, bits[22:0], 29'd0};
         x = $bitstoreal(dbits);
      end
      if (x < -1.0) x = -1.0;
      if (x > 1.0) x = 1.0;
      neg_s = 64'sd1 <<< (n - 1);
      pos_s = neg_s - 1;
      scaled = (x >= 0.0) ? x * real'(pos_s) : x * real'(neg_s);
      mag = (scaled < 0.0) ? -scaled : scaled;
      fl = $floor(mag);
      whole = longint'(fl);
      if (mag - fl >= 0.5) whole++;
      q = (scaled < 0.0) ? -whole : whole;
      if (q < -neg_s) q = -neg_s;
      if (q > pos_s) q = pos_s;
      return q;
   endfunction

   function automatic logic [31:0] pack_pcm(logic [31:0] bits);
      int          nbytes, cbits, shift;
      longint      v;
      logic [63:0] raw, mask;
      nbytes = (cfg_bytes > fpsp_pkg::MAX_BYTES) ? int'(fpsp_pkg::MAX_BYTES)
                                                 : int'(cfg_bytes);
      if (nbytes == 0) return 32'd0;
      if (cfg_unsigned) begin
         v = quantize_sample(bits, int'(fpsp_pkg::UNSIGNED_BITS)) + 128;
         if (v < 0) v = 0;
         if (v > 255) v = 255;
         return {24'd0, v[7:0]};
      end
      cbits = nbytes * 8;
      shift = (cbits > int'(cfg_vbits)) ? cbits - int'(cfg_vbits) : 0;
      raw = quantize_sample(bits, int'(cfg_vbits));
      mask = (64'd1 << cbits) - 64'd1;
      return 32'((raw << shift) & mask);
   endfunction

   // clock and cycle limit
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", pcm_expected.size());
         $display("FAILURE");
         $finish;
      end
   end

   // result side: random stall, about 7 in 100
   always @(posedge clock) begin
      if (reset || quiet) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < 7);
   end

   // result checker
   logic [31:0] pcm_want;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pcm_expected.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result pcm_word=%h", rsp_pcm_word);
         end else begin
            pcm_want = pcm_expected.pop_front();
            checked_count++;
            if (rsp_pcm_word !== pcm_want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("pcm_word mismatch: expected %h actual %h", pcm_want,
                           rsp_pcm_word);
            end
         end
      end
   end

   // one input transaction; the caller's valid stays up between back-to-back items
   task automatic send_sample(logic [31:0] bits, bit typed, logic [31:0] pcm);
      int gap;
      req_valid <= 1'b1;
      req_sample_float <= bits;
      do @(posedge clock); while (!(req_valid && !req_stall));
      pcm_expected.push_back(typed ? pcm : pack_pcm(bits));
      sample_count++;
      if (!quiet && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(logic [31:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      if (idx == fpsp_pkg::REG_CONTAINER_BYTES) cfg_bytes = data[2:0];
      else if (idx == fpsp_pkg::REG_VALID_BITS) cfg_vbits = data[5:0];
      else if (idx == fpsp_pkg::REG_UNSIGNED_MODE) cfg_unsigned = data[0];
   endtask

   // sender holds off until everything in flight has come back
   task automatic drain_all();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pcm_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // mostly in-range samples with random mantissa, some raw patterns and specials
   function automatic logic [31:0] random_sample();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) return {1'($urandom), 8'($urandom_range(96, 127)), 23'($urandom)};
      if (pick < 80) return {1'($urandom), 8'($urandom_range(127, 130)), 23'($urandom)};
      if (pick < 85) return {1'($urandom), 8'hFF, ($urandom_range(1) ? 23'd0 : 23'($urandom))};
      if (pick < 90) return {1'($urandom), 8'h00, 23'($urandom)};
      return $urandom;
   endfunction

   initial begin
      int per_phase;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_float = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      rsp_stall = 1'b0;
      quiet = 1'b0;
      cycle_count = 0;
      mismatch_count = 0;
      checked_count = 0;
      sample_count = 0;
      cfg_bytes = fpsp_pkg::CONTAINER_BYTES_RESET;
      cfg_vbits = fpsp_pkg::VALID_BITS_RESET;
      cfg_unsigned = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows under the reset setting
      foreach (sample_table[i])
         send_sample(sample_table[i].sample, sample_table[i].typed, sample_table[i].pcm);
      drain_all();

      // random items across every setting, then a few random settings
      per_phase = RANDOM_ITEMS / (setting_list.size() + 4);
      for (int p = 0; p < setting_list.size() + 4; p++) begin
         if (p < setting_list.size()) begin
            write_reg(fpsp_pkg::REG_CONTAINER_BYTES, setting_list[p].bytes);
            write_reg(fpsp_pkg::REG_VALID_BITS, setting_list[p].vbits);
            write_reg(fpsp_pkg::REG_UNSIGNED_MODE, setting_list[p].unsg);
         end else begin
            write_reg(fpsp_pkg::REG_CONTAINER_BYTES, $urandom);
            write_reg(fpsp_pkg::REG_VALID_BITS, $urandom);
            write_reg(fpsp_pkg::REG_UNSIGNED_MODE, $urandom);
         end
         csr_valid <= 1'b0;
         quiet = (p == 3);   // one long stretch at full rate
         for (int i = 0; i < per_phase; i++) send_sample(random_sample(), 0, 32'd0);
         drain_all();
         quiet = 1'b0;
      end

      $display("covered %0d samples over %0d register settings, %0d results checked",
               sample_count, setting_list.size() + 5, checked_count);
      if (mismatch_count == 0 && pcm_expected.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- float_to_pcm_sample_packer_top.f -----
+incdir+src
src/fpsp_pkg.sv
src/fpsp_csr.sv
src/fpsp_quant.sv
src/fpsp_pack.sv
src/float_to_pcm_sample_packer_top.sv
tb/float_to_pcm_sample_packer_top_test.sv
